/* rtl/mips_itype_execute_unit_macros.svh */
// Assertion macros for the MIPS I-type execute unit.
`ifndef MIPS_ITYPE_EXECUTE_UNIT_MACROS_SVH
`define MIPS_ITYPE_EXECUTE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define MIEX_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MIEX_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MIEX_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MIEX_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/miex_pkg.sv */
// Shared types and opcode constants for the MIPS I-type execute unit.
`default_nettype none
package miex_pkg;
   localparam int QDEPTH = 2;

   localparam logic [5:0] OPC_BEQ   = 6'h04;
   localparam logic [5:0] OPC_BNE   = 6'h05;
   localparam logic [5:0] OPC_ADDI  = 6'h08;
   localparam logic [5:0] OPC_ADDIU = 6'h09;
   localparam logic [5:0] OPC_SLTI  = 6'h0A;
   localparam logic [5:0] OPC_SLTIU = 6'h0B;
   localparam logic [5:0] OPC_ANDI  = 6'h0C;
   localparam logic [5:0] OPC_ORI   = 6'h0D;
   localparam logic [5:0] OPC_XORI  = 6'h0E;
   localparam logic [5:0] OPC_LUI   = 6'h0F;
   localparam logic [5:0] OPC_LB    = 6'h20;
   localparam logic [5:0] OPC_LH    = 6'h21;
   localparam logic [5:0] OPC_LW    = 6'h23;
   localparam logic [5:0] OPC_LBU   = 6'h24;
   localparam logic [5:0] OPC_LHU   = 6'h25;
   localparam logic [5:0] OPC_SB    = 6'h28;
   localparam logic [5:0] OPC_SH    = 6'h29;
   localparam logic [5:0] OPC_SW    = 6'h2B;

   typedef enum logic [4:0] {
      OP_ADD, OP_SLT, OP_SLTU, OP_AND, OP_OR, OP_XOR, OP_LUI, OP_BEQ, OP_BNE,
      OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_SB, OP_SH, OP_SW, OP_ILL
   } op_class_type;

   typedef struct packed {
      op_class_type op;
      logic         is_load;
      logic         is_store;
      logic         writes_reg;
      logic [4:0]   rs;
      logic [4:0]   rt;
      logic [15:0]  imm;
      logic [31:0]  pc;
   } uop_type;
endpackage
`default_nettype wire

/* rtl/miex_front.sv */
// Front end: decodes an instruction beat into a classified micro-op.
`default_nettype none
module miex_front
   import miex_pkg::*;
(
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_current_pc,
   output uop_type     uop
);
   logic [5:0] opcode;

   assign opcode = req_instr_word[31:26];

   always_comb begin
      uop.rs = req_instr_word[25:21];
      uop.rt = req_instr_word[20:16];
      uop.imm = req_instr_word[15:0];
      uop.pc = req_current_pc;
      case (opcode)
         OPC_ADDI:  uop.op = OP_ADD;
         OPC_ADDIU: uop.op = OP_ADD;
         OPC_SLTI:  uop.op = OP_SLT;
         OPC_SLTIU: uop.op = OP_SLTU;
         OPC_ANDI:  uop.op = OP_AND;
         OPC_ORI:   uop.op = OP_OR;
         OPC_XORI:  uop.op = OP_XOR;
         OPC_LUI:   uop.op = OP_LUI;
         OPC_BEQ:   uop.op = OP_BEQ;
         OPC_BNE:   uop.op = OP_BNE;
         OPC_LB:    uop.op = OP_LB;
         OPC_LBU:   uop.op = OP_LBU;
         OPC_LH:    uop.op = OP_LH;
         OPC_LHU:   uop.op = OP_LHU;
         OPC_LW:    uop.op = OP_LW;
         OPC_SB:    uop.op = OP_SB;
         OPC_SH:    uop.op = OP_SH;
         OPC_SW:    uop.op = OP_SW;
         default:   uop.op = OP_ILL;
      endcase
      uop.is_load = (uop.op == OP_LB) || (uop.op == OP_LBU) || (uop.op == OP_LH) ||
                    (uop.op == OP_LHU) || (uop.op == OP_LW);
      uop.is_store = (uop.op == OP_SB) || (uop.op == OP_SH) || (uop.op == OP_SW);
      uop.writes_reg = !uop.is_store && (uop.op != OP_BEQ) && (uop.op != OP_BNE) &&
                       (uop.op != OP_ILL);
   end
endmodule
`default_nettype wire

/* rtl/miex_queue.sv */
// Short FIFO of decoded micro-ops between the front end and the back end.
`default_nettype none
module miex_queue
   import miex_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  uop_type push_uop,
   output logic    full,
   input  logic    pop,
   output uop_type head_uop,
   output logic    empty
);
   localparam int QPW = $clog2(QDEPTH);

   uop_type          q_ff [QDEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPW:0]     count_ff, count_in;

   assign full = (count_ff == (QPW+1)'(QDEPTH));
   assign empty = (count_ff == '0);
   assign head_uop = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPW'(1) : rd_ptr_ff;
      count_in = count_ff + (QPW+1)'(push) - (QPW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_uop;
      end
   end
endmodule
`default_nettype wire

/* rtl/miex_back.sv */
// Back end: register read with forwarding, execute and memory, result register.
`default_nettype none
module miex_back
   import miex_pkg::*;
#(
   parameter int MEM_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  uop_type     head_uop,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_branch_taken,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic        rsp_mem_written,
   output logic [11:0] rsp_mem_address,
   output logic        rsp_illegal_op
);
   localparam int AW = $clog2(MEM_BYTES);
   localparam int ROWS = MEM_BYTES / 4;

   logic [31:0]   rf_ff [32];
   logic [31:0]   rf_vld_ff;

   logic          s2_valid_ff, s2_valid_in;
   uop_type       s2_uop_ff;
   logic [31:0]   s2_a_ff, s2_b_ff, s2_a_in, s2_b_in;

   logic          s3_valid_ff, s3_valid_in;
   op_class_type  s3_op_ff;
   logic [31:0]   s3_npc_ff, s3_val_ff;
   logic          s3_taken_ff, s3_wr_ff, s3_mw_ff, s3_mem_ff, s3_ill_ff, s3_ld_ff;
   logic [4:0]    s3_rt_ff;
   logic [AW-1:0] s3_addr_ff;

   logic          s3_adv, s2_adv, s2_fire, hazard, head_reads_rs, head_reads_rt;
   logic [31:0]   simm, zimm, alu, npc, addr_full, s3_result, ld_word, ld_val;
   logic          taken;
   logic [AW-1:0] addr;
   logic [7:0]    bank_rdata [4];
   logic [7:0]    ld_byte [4];

   function automatic logic [31:0] rf_read(input logic [31:0] vld, input logic [31:0] d);
      logic [31:0] r;
      r = vld[0] ? d : '0;
      return r;
   endfunction

   assign s3_adv = !s3_valid_ff || rsp_ready;
   assign s2_adv = !s2_valid_ff || s3_adv;
   assign s2_fire = s2_valid_ff && s3_adv;
   assign head_reads_rs = (head_uop.op != OP_LUI) && (head_uop.op != OP_ILL);
   assign head_reads_rt = head_uop.is_store || (head_uop.op == OP_BEQ) ||
                          (head_uop.op == OP_BNE);
   assign hazard = s2_valid_ff && s2_uop_ff.is_load &&
                   ((head_reads_rs && (s2_uop_ff.rt == head_uop.rs)) ||
                    (head_reads_rt && (s2_uop_ff.rt == head_uop.rt)));
   assign pop = head_valid && s2_adv && !hazard;

   always_comb begin
      simm = {{16{s2_uop_ff.imm[15]}}, s2_uop_ff.imm};
      zimm = {16'h0000, s2_uop_ff.imm};
      taken = 1'b0;
      case (s2_uop_ff.op)
         OP_ADD:  alu = s2_a_ff + simm;
         OP_SLT:  alu = {31'd0, $signed(s2_a_ff) < $signed(simm)};
         OP_SLTU: alu = {31'd0, s2_a_ff < simm};
         OP_AND:  alu = s2_a_ff & zimm;
         OP_OR:   alu = s2_a_ff | zimm;
         OP_XOR:  alu = s2_a_ff ^ zimm;
         OP_LUI:  alu = {s2_uop_ff.imm, 16'h0000};
         OP_BEQ: begin
            alu = '0;
            taken = (s2_a_ff == s2_b_ff);
         end
         OP_BNE: begin
            alu = '0;
            taken = (s2_a_ff != s2_b_ff);
         end
         default: alu = '0;
      endcase
      npc = s2_uop_ff.pc + 32'd4 + (taken ? {simm[29:0], 2'b00} : 32'd0);
      addr_full = s2_a_ff + simm;
      addr = addr_full[AW-1:0];
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ld_byte[k] = bank_rdata[2'(s3_addr_ff[1:0] + 2'(k))];
      end
      ld_word = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
      case (s3_op_ff)
         OP_LB:   ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
         OP_LBU:  ld_val = {24'd0, ld_word[7:0]};
         OP_LH:   ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
         OP_LHU:  ld_val = {16'd0, ld_word[15:0]};
         default: ld_val = ld_word;
      endcase
      s3_result = s3_ld_ff ? ld_val : s3_val_ff;
   end

   always_comb begin
      if (s2_valid_ff && s2_uop_ff.writes_reg && !s2_uop_ff.is_load &&
          s2_uop_ff.rt == head_uop.rs) begin
         s2_a_in = alu;
      end else if (s3_valid_ff && s3_wr_ff && s3_rt_ff == head_uop.rs) begin
         s2_a_in = s3_result;
      end else begin
         s2_a_in = rf_read(32'(rf_vld_ff[head_uop.rs]), rf_ff[head_uop.rs]);
      end
      if (s2_valid_ff && s2_uop_ff.writes_reg && !s2_uop_ff.is_load &&
          s2_uop_ff.rt == head_uop.rt) begin
         s2_b_in = alu;
      end else if (s3_valid_ff && s3_wr_ff && s3_rt_ff == head_uop.rt) begin
         s2_b_in = s3_result;
      end else begin
         s2_b_in = rf_read(32'(rf_vld_ff[head_uop.rt]), rf_ff[head_uop.rt]);
      end
      s2_valid_in = s2_adv ? pop : s2_valid_ff;
      s3_valid_in = s3_adv ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rf_vld_ff <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         if (s3_valid_ff && s3_wr_ff) begin
            rf_vld_ff[s3_rt_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && s3_wr_ff) begin
         rf_ff[s3_rt_ff] <= s3_result;
      end
      if (pop) begin
         s2_uop_ff <= head_uop;
         s2_a_ff <= s2_a_in;
         s2_b_ff <= s2_b_in;
      end
      if (s2_fire) begin
         s3_op_ff <= s2_uop_ff.op;
         s3_npc_ff <= npc;
         s3_taken_ff <= taken;
         s3_wr_ff <= s2_uop_ff.writes_reg;
         s3_rt_ff <= s2_uop_ff.rt;
         s3_val_ff <= alu;
         s3_mw_ff <= s2_uop_ff.is_store;
         s3_mem_ff <= s2_uop_ff.is_load || s2_uop_ff.is_store;
         s3_ld_ff <= s2_uop_ff.is_load;
         s3_ill_ff <= (s2_uop_ff.op == OP_ILL);
         s3_addr_ff <= addr;
      end
   end

   for (genvar j = 0; j < 4; j++) begin : g_bank
      logic [7:0]    mem_bank [ROWS];
      logic [7:0]    rd_byte_ff;
      logic [1:0]    k;
      logic [AW-1:0] byte_addr;
      logic          we;
      logic [7:0]    wdata;

      always_comb begin
         k = 2'(j) - addr[1:0];
         byte_addr = addr + AW'(k);
         case (s2_uop_ff.op)
            OP_SB:   we = (k == 2'd0);
            OP_SH:   we = (k <= 2'd1);
            OP_SW:   we = 1'b1;
            default: we = 1'b0;
         endcase
         wdata = 8'(s2_b_ff >> {k, 3'b000});
      end

      always_ff @(posedge clock) begin
         if (s2_fire) begin
            if (we) begin
               mem_bank[byte_addr[AW-1:2]] <= wdata;
            end
            rd_byte_ff <= mem_bank[byte_addr[AW-1:2]];
         end
      end

      assign bank_rdata[j] = rd_byte_ff;
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_next_pc = s3_npc_ff;
   assign rsp_branch_taken = s3_taken_ff;
   assign rsp_reg_written = s3_wr_ff;
   assign rsp_dest_index = s3_wr_ff ? s3_rt_ff : '0;
   assign rsp_dest_value = s3_wr_ff ? s3_result : '0;
   assign rsp_mem_written = s3_mw_ff;
   assign rsp_mem_address = s3_mem_ff ? 12'(s3_addr_ff) : '0;
   assign rsp_illegal_op = s3_ill_ff;
endmodule
`default_nettype wire

/* rtl/mips_itype_execute_unit.sv */
// Top level of the MIPS I-type execute unit.
// The unit takes one instruction beat per clock while req_ready is high and
// returns one result beat per instruction, in order. It sustains one
// instruction per cycle while results are taken; the one exception is a load
// followed directly by an instruction that reads the loaded register, which
// waits because load data comes from the data memory bank registers, which
// capture it when the load leaves the address stage. The data memory is four
// byte-wide banks of MEM_BYTES/4 entries (MEM_BYTES a power of two), so any
// aligned or unaligned access touches each bank once. A two-entry queue
// separates decode from execution; input and result sides stall independently.
`default_nettype none
`include "mips_itype_execute_unit_macros.svh"
module mips_itype_execute_unit
   import miex_pkg::*;
#(
   parameter int MEM_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_current_pc,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_branch_taken,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic        rsp_mem_written,
   output logic [11:0] rsp_mem_address,
   output logic        rsp_illegal_op
);
   uop_type dec_uop, head_uop;
   logic    q_full, q_empty, q_pop, push;

   assign req_ready = !q_full;
   assign push = req_valid && req_ready;

   miex_front u_front (
      .req_instr_word (req_instr_word),
      .req_current_pc (req_current_pc),
      .uop            (dec_uop)
   );

   miex_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_uop (dec_uop),
      .full     (q_full),
      .pop      (q_pop),
      .head_uop (head_uop),
      .empty    (q_empty)
   );

   miex_back #(.MEM_BYTES(MEM_BYTES)) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (!q_empty),
      .head_uop         (head_uop),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_reg_written  (rsp_reg_written),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_dest_value   (rsp_dest_value),
      .rsp_mem_written  (rsp_mem_written),
      .rsp_mem_address  (rsp_mem_address),
      .rsp_illegal_op   (rsp_illegal_op)
   );

   `MIEX_ASSERT_NXT(a_push_fills, clock, reset, push, !q_empty, "queue empty after a push")
   `MIEX_ASSERT_IMP(a_illegal_quiet, clock, reset, rsp_valid && rsp_illegal_op,
      !rsp_reg_written && !rsp_mem_written && !rsp_branch_taken,
      "illegal beat has side effects")
   `MIEX_ASSERT_IMP(a_store_excl, clock, reset, rsp_valid && rsp_mem_written,
      !rsp_reg_written && !rsp_branch_taken, "store beat also writes a register")
endmodule
`default_nettype wire
